FILE: rtl/core/sftl_pkg.sv
// Package for the strip/fan to triangle-list converter.
// Primitive codes, counter limits and the load descriptor shared by the core modules.
// No dependencies.
package sftl_pkg;

    localparam int INDEX_BITS_DEF = 32;

    localparam logic [1:0] PRIM_TRIANGLES = 2'd0;
    localparam logic [1:0] PRIM_STRIP     = 2'd1;
    localparam logic [1:0] PRIM_FAN       = 2'd2;

    localparam logic [1:0] SEEN_FULL = 2'd3;

    localparam logic [1:0] COUNT_ONE   = 2'd1;
    localparam logic [1:0] COUNT_THREE = 2'd3;

    // one accepted vertex item handed to the result queue
    typedef struct packed {
        logic       load;
        logic [1:0] count;
    } sftl_load_t;

endpackage

FILE: rtl/core/sftl_assembler.sv
// Primitive assembly state and index selection for one accepted item.
// Depends on sftl_pkg.
module sftl_assembler #(
    parameter int INDEX_BITS = sftl_pkg::INDEX_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       accept,
    input  logic                       mode,
    input  logic [1:0]                 prim_type,
    input  logic [INDEX_BITS-1:0]      vertex_index,
    output sftl_pkg::sftl_load_t       load,
    output logic [2:0][INDEX_BITS-1:0] tri_index
);
    import sftl_pkg::*;

    logic [1:0]            prim_kind_reg, prim_kind_next;
    logic [1:0]            seen_count_reg, seen_count_next;
    logic                  strip_phase_reg, strip_phase_next;
    logic [INDEX_BITS-1:0] fan_first_reg, fan_first_next;
    logic [INDEX_BITS-1:0] out_last_reg, out_last_next;
    logic [INDEX_BITS-1:0] out_second_reg, out_second_next;
    logic [INDEX_BITS-1:0] out_third_reg, out_third_next;

    logic                  is_strip, is_fan, expand;
    logic [INDEX_BITS-1:0] pick_a, pick_b;

    assign is_strip = (seen_count_reg == SEEN_FULL) && (prim_kind_reg == PRIM_STRIP);
    assign is_fan   = (seen_count_reg == SEEN_FULL) && (prim_kind_reg == PRIM_FAN);
    assign expand   = is_strip || is_fan;

    always_comb begin
        if (is_fan) begin
            pick_a = fan_first_reg;
            pick_b = out_last_reg;
        end else if (strip_phase_reg) begin
            pick_a = out_third_reg;
            pick_b = out_last_reg;
        end else begin
            pick_a = out_last_reg;
            pick_b = out_second_reg;
        end
    end

    always_comb begin
        prim_kind_next   = prim_kind_reg;
        seen_count_next  = seen_count_reg;
        strip_phase_next = strip_phase_reg;
        fan_first_next   = fan_first_reg;
        out_last_next    = out_last_reg;
        out_second_next  = out_second_reg;
        out_third_next   = out_third_reg;
        load.load        = 1'b0;
        load.count       = COUNT_ONE;
        tri_index[0]     = vertex_index;
        tri_index[1]     = pick_b;
        tri_index[2]     = vertex_index;
        if (expand) begin
            tri_index[0] = pick_a;
        end
        if (accept) begin
            if (mode) begin
                prim_kind_next   = prim_type;
                seen_count_next  = '0;
                strip_phase_next = 1'b0;
            end else begin
                load.load = 1'b1;
                if (seen_count_reg == '0) begin
                    fan_first_next = vertex_index;
                end
                out_last_next = vertex_index;
                if (expand) begin
                    load.count      = COUNT_THREE;
                    out_third_next  = pick_a;
                    out_second_next = pick_b;
                    if (is_strip) begin
                        strip_phase_next = ~strip_phase_reg;
                    end
                end else begin
                    out_third_next  = out_second_reg;
                    out_second_next = out_last_reg;
                    if (seen_count_reg != SEEN_FULL) begin
                        seen_count_next = seen_count_reg + 2'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prim_kind_reg   <= PRIM_TRIANGLES;
            seen_count_reg  <= '0;
            strip_phase_reg <= 1'b0;
        end else begin
            prim_kind_reg   <= prim_kind_next;
            seen_count_reg  <= seen_count_next;
            strip_phase_reg <= strip_phase_next;
        end
    end

    // history is always written before it is read
    always_ff @(posedge aclk) begin
        fan_first_reg  <= fan_first_next;
        out_last_reg   <= out_last_next;
        out_second_reg <= out_second_next;
        out_third_reg  <= out_third_next;
    end

endmodule

FILE: rtl/core/sftl_queue.sv
// Result queue: holds up to three pending indices and drives the output register.
// Depends on sftl_pkg.
module sftl_queue #(
    parameter int INDEX_BITS = sftl_pkg::INDEX_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  sftl_pkg::sftl_load_t       load,
    input  logic [2:0][INDEX_BITS-1:0] tri_index,
    output logic                       can_load,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [INDEX_BITS-1:0]      m_out_index,
    output logic                       m_last
);
    import sftl_pkg::*;

    logic [2:0][INDEX_BITS-1:0] buf_reg, buf_next;
    logic [2:0]                 last_reg, last_next;
    logic [1:0]                 cnt_reg, cnt_next;
    logic                       m_valid_reg;
    logic [INDEX_BITS-1:0]      out_index_reg;
    logic                       out_last_reg;
    logic                       move;

    assign move     = (cnt_reg != '0) && (!m_valid_reg || m_ready);
    assign can_load = (cnt_reg == '0) || ((cnt_reg == 2'd1) && move);

    always_comb begin
        buf_next  = buf_reg;
        last_next = last_reg;
        cnt_next  = cnt_reg;
        if (load.load) begin
            buf_next = tri_index;
            cnt_next = load.count;
            if (load.count == COUNT_THREE) begin
                last_next = 3'b100;
            end else begin
                last_next = 3'b001;
            end
        end else if (move) begin
            buf_next[0]  = buf_reg[1];
            buf_next[1]  = buf_reg[2];
            last_next    = {1'b0, last_reg[2:1]};
            cnt_next     = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (move) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        buf_reg  <= buf_next;
        last_reg <= last_next;
        if (move) begin
            out_index_reg <= buf_reg[0];
            out_last_reg  <= last_reg[0];
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_index = out_index_reg;
    assign m_last      = out_last_reg;

endmodule

FILE: rtl/core/strip_fan_to_triangle_list.sv
// Top level of the strip/fan to triangle-list converter.
// Instantiates sftl_assembler and sftl_queue; depends on sftl_pkg.
//
// Usage:
//   Input channel s_*: one item per handshake. s_mode high is a begin item that
//   sets the primitive type from s_prim_type and yields no result. s_mode low is
//   a vertex item carrying s_vertex_index.
//   Result channel m_*: one triangle-list index per handshake, m_last marks the
//   final index caused by one vertex item.
//   Path: an accepted vertex item is loaded into the queue register, then each of
//   its indices moves on to the output register, which drives m_valid and m_out_index.
//   Throughput: the output register takes one index a cycle from the three-entry
//   queue unless stalled by m_ready low; an expanded strip or fan vertex yields three
//   indices, a pass-through vertex one and a begin item none.
//   Reset: aresetn low holds s_ready low, empties the queue and output register
//   and selects triangles with no vertices seen.
//   Stall: while m_ready is low the output holds; a new item is taken only once
//   the queue has handed its last pending index to the output register.
module strip_fan_to_triangle_list #(
    parameter int INDEX_BITS = sftl_pkg::INDEX_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_mode,
    input  logic [1:0]            s_prim_type,
    input  logic [INDEX_BITS-1:0] s_vertex_index,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [INDEX_BITS-1:0] m_out_index,
    output logic                  m_last
);
    import sftl_pkg::*;

    sftl_load_t                 load;
    logic [2:0][INDEX_BITS-1:0] tri_index;
    logic                       can_load;

    assign s_ready = can_load && aresetn;

    sftl_assembler #(
        .INDEX_BITS(INDEX_BITS)
    ) u_assembler (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (s_valid && s_ready),
        .mode        (s_mode),
        .prim_type   (s_prim_type),
        .vertex_index(s_vertex_index),
        .load        (load),
        .tri_index   (tri_index)
    );

    sftl_queue #(
        .INDEX_BITS(INDEX_BITS)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (load),
        .tri_index  (tri_index),
        .can_load   (can_load),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_index(m_out_index),
        .m_last     (m_last)
    );

endmodule

FILE: rtl/core/sftl_checker.sv
// Port-level assertions for strip_fan_to_triangle_list, with its bind.
// Depends on sftl_pkg and the top level's ports.
module sftl_checker #(
    parameter int INDEX_BITS = sftl_pkg::INDEX_BITS_DEF
) (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [INDEX_BITS-1:0] m_out_index,
    input logic                  m_last
);
    import sftl_pkg::*;

    // output holds while stalled
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_index) && $stable(m_last))
        else $error("result item changed while stalled");

    // remaining indices of a triangle follow without a gap
    a_burst: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last |=> m_valid)
        else $error("gap inside a triangle");

    // no new item while an unfinished triangle is stalled
    a_no_take: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last && !m_ready |-> !s_ready)
        else $error("input taken while results pending");

    // nothing comes out straight after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind strip_fan_to_triangle_list sftl_checker #(
    .INDEX_BITS(INDEX_BITS)
) u_sftl_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_out_index(m_out_index),
    .m_last     (m_last)
);

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for strip_fan_to_triangle_list: directed and random
// primitives, with a predictor that expands strips and fans into triangle lists.
// Depends on sftl_pkg and the converter RTL.
module tb_top;
    import sftl_pkg::*;

    localparam int IDX_W = INDEX_BITS_DEF;
    localparam int ITEMS_TOTAL = 420;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES = 12;

    localparam logic MODE_VERTEX = 1'b0;
    localparam logic MODE_BEGIN  = 1'b1;
    localparam logic [1:0] PRIM_UNKNOWN = 2'd3;

    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic             last;
    } index_result_t;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    logic             s_mode = MODE_VERTEX;
    logic [1:0]       s_prim_type = PRIM_TRIANGLES;
    logic [IDX_W-1:0] s_vertex_index = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic [IDX_W-1:0] m_out_index;
    logic             m_last;

    // predictor state
    logic [1:0]       prim_kind = PRIM_TRIANGLES;
    logic [1:0]       seen_count = '0;
    logic             strip_phase = 1'b0;
    logic [IDX_W-1:0] fan_first = '0;
    logic [IDX_W-1:0] hist_newest = '0;
    logic [IDX_W-1:0] hist_middle = '0;
    logic [IDX_W-1:0] hist_oldest = '0;

    index_result_t pending_indices[$];
    int            mismatches = 0;
    int            items_sent = 0;
    int            src_idle_max = 3;
    int            sink_idle_max = 3;
    int            stall_left = 0;

    strip_fan_to_triangle_list #(
        .INDEX_BITS(IDX_W)
    ) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_prim_type   (s_prim_type),
        .s_vertex_index(s_vertex_index),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_index   (m_out_index),
        .m_last        (m_last)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic void queue_index(input logic [IDX_W-1:0] idx, input logic last);
        index_result_t r;
        r.index = idx;
        r.last  = last;
        pending_indices = {pending_indices, r};
        hist_oldest = hist_middle;
        hist_middle = hist_newest;
        hist_newest = idx;
    endfunction

    function automatic void predict_indices(input logic mode, input logic [1:0] ptype,
                                            input logic [IDX_W-1:0] vidx);
        logic [IDX_W-1:0] a;
        logic [IDX_W-1:0] b;
        if (mode == MODE_BEGIN) begin
            prim_kind   = ptype;
            seen_count  = '0;
            strip_phase = 1'b0;
            return;
        end
        if (seen_count == '0)
            fan_first = vidx;
        if (seen_count == SEEN_FULL && prim_kind == PRIM_STRIP) begin
            if (strip_phase) begin
                a = hist_oldest;
                b = hist_newest;
            end else begin
                a = hist_newest;
                b = hist_middle;
            end
            strip_phase = ~strip_phase;
            queue_index(a, 1'b0);
            queue_index(b, 1'b0);
            queue_index(vidx, 1'b1);
        end else if (seen_count == SEEN_FULL && prim_kind == PRIM_FAN) begin
            a = fan_first;
            b = hist_newest;
            queue_index(a, 1'b0);
            queue_index(b, 1'b0);
            queue_index(vidx, 1'b1);
        end else begin
            if (seen_count != SEEN_FULL)
                seen_count = seen_count + 2'd1;
            queue_index(vidx, 1'b1);
        end
    endfunction

    task automatic send_item(input logic mode, input logic [1:0] ptype,
                             input logic [IDX_W-1:0] vidx);
        int gap;
        gap = $urandom_range(0, src_idle_max);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_mode         <= mode;
        s_prim_type    <= ptype;
        s_vertex_index <= vidx;
        predict_indices(mode, ptype, vidx);
        items_sent++;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    function automatic logic [IDX_W-1:0] rand_index();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return IDX_W'($urandom_range(0, 15));
            default: return IDX_W'($urandom);
        endcase
    endfunction

    task automatic send_vertex(input logic [IDX_W-1:0] vidx);
        send_item(MODE_VERTEX, 2'($urandom_range(0, 3)), vidx);
    endtask

    task automatic send_begin(input logic [1:0] ptype);
        send_item(MODE_BEGIN, ptype, IDX_W'($urandom));
    endtask

    // result side: random stalls, compare against oldest expectation
    always @(posedge aclk) begin : result_sink
        int stall;
        index_result_t exp_r;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (m_valid && m_ready) begin
            if (pending_indices.size() == 0) begin
                $display("%0t: unexpected item: index %h last %b",
                         $time, m_out_index, m_last);
                mismatches++;
            end else begin
                exp_r = pending_indices.pop_front();
                if (m_out_index !== exp_r.index) begin
                    $display("%0t: out_index expected %h actual %h",
                             $time, exp_r.index, m_out_index);
                    mismatches++;
                end
                if (m_last !== exp_r.last) begin
                    $display("%0t: last expected %b actual %b",
                             $time, exp_r.last, m_last);
                    mismatches++;
                end
            end
            stall = $urandom_range(0, sink_idle_max);
            m_ready <= (stall == 0);
            stall_left = (stall == 0) ? 0 : stall - 1;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout after %0d idle cycles", WATCHDOG_LIMIT);
        $display("status: fail");
        $finish;
    end

    // vertices before any begin use triangles
    task automatic test_default_type();
        send_vertex('0);
        send_vertex('1);
        send_vertex(IDX_W'(32'h5555_AAAA));
        send_vertex(IDX_W'(32'hAAAA_5555));
    endtask

    task automatic test_triangles();
        send_begin(PRIM_TRIANGLES);
        send_vertex(IDX_W'(1));
        send_vertex(IDX_W'(2));
        send_vertex(IDX_W'(3));
        send_vertex('1);
    endtask

    task automatic test_strip();
        send_begin(PRIM_STRIP);
        send_vertex(IDX_W'(10));
        send_vertex(IDX_W'(11));
        send_vertex('1);
        send_vertex('0);
        send_vertex(IDX_W'(14));
    endtask

    task automatic test_fan();
        send_begin(PRIM_FAN);
        send_vertex('1);
        send_vertex(IDX_W'(21));
        send_vertex(IDX_W'(22));
        send_vertex(IDX_W'(23));
        send_vertex('0);
    endtask

    task automatic test_unknown_type();
        send_begin(PRIM_UNKNOWN);
        send_vertex(IDX_W'(30));
        send_vertex(IDX_W'(31));
        send_vertex(IDX_W'(32));
    endtask

    task automatic test_random_primitives();
        int roll;
        int n_vert;
        logic [1:0] ptype;
        while (items_sent < ITEMS_TOTAL) begin
            src_idle_max  = ($urandom_range(0, 3) == 0) ? 0 : 3;
            sink_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 3;
            roll = $urandom_range(0, 9);
            if (roll == 0) begin
                // broken sequence: begin with no vertices, or stray vertices
                if ($urandom_range(0, 1))
                    send_begin(2'($urandom_range(0, 3)));
                else
                    send_vertex(rand_index());
            end else begin
                roll = $urandom_range(0, 9);
                if (roll < 4)
                    ptype = PRIM_STRIP;
                else if (roll < 8)
                    ptype = PRIM_FAN;
                else if (roll == 8)
                    ptype = PRIM_TRIANGLES;
                else
                    ptype = PRIM_UNKNOWN;
                send_begin(ptype);
                n_vert = $urandom_range(0, 14);
                repeat (n_vert) send_vertex(rand_index());
            end
        end
    endtask

    initial begin : main
        aresetn <= 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_default_type();
        test_triangles();
        test_strip();
        test_fan();
        test_unknown_type();
        test_random_primitives();

        s_valid <= 1'b0;
        while (pending_indices.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/sftl_pkg.sv
rtl/core/sftl_assembler.sv
rtl/core/sftl_queue.sv
rtl/core/strip_fan_to_triangle_list.sv
rtl/core/sftl_checker.sv
tb/sv/tb_top.sv
